FILE: rtl/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared types and constants for the learning switch forwarder.
// ----------------------------------------------------------------------------
`default_nettype none

package lsf_pkg;

   localparam int PORT_COUNT   = 8;
   localparam int PORT_BITS    = $clog2(PORT_COUNT);
   localparam int ADDRESS_BITS = 48;
   localparam int CSR_BITS     = 4;

   localparam logic [CSR_BITS-1:0] CSR_RESET = CSR_BITS'(8);

   localparam logic [1:0] OP_CONNECT    = 2'd0;
   localparam logic [1:0] OP_FRAME      = 2'd1;
   localparam logic [1:0] OP_DISCONNECT = 2'd2;

   typedef struct packed {
      logic [1:0]              operation;
      logic [PORT_BITS-1:0]    port;
      logic [ADDRESS_BITS-1:0] source_address;
      logic [ADDRESS_BITS-1:0] destination_address;
   } lsf_req_type;

   typedef struct packed {
      logic                  accepted;
      logic [PORT_BITS-1:0]  assigned_port;
      logic [PORT_COUNT-1:0] forward_mask;
      logic                  destination_found;
   } lsf_rsp_type;

   typedef struct packed {
      logic                    we;
      logic [PORT_BITS-1:0]    addr;
      logic [ADDRESS_BITS-1:0] wdata;
   } lsf_ram_req_type;

endpackage

`default_nettype wire

FILE: rtl/lsf_ram.sv
// ----------------------------------------------------------------------------
// lsf_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

`default_nettype wire

FILE: rtl/lsf_ctrl.sv
// ----------------------------------------------------------------------------
// lsf_ctrl
// Request sequencer: port flags, learn write and address table scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_ctrl (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   start,
   output logic                                        busy,
   input  wire lsf_pkg::lsf_req_type                   req,
   output logic                                        rsp_strobe,
   output lsf_pkg::lsf_rsp_type                        rsp,
   input  wire logic [lsf_pkg::CSR_BITS-1:0]           port_count,
   input  wire logic [lsf_pkg::PORT_COUNT-1:0]         enable_mask,
   output lsf_pkg::lsf_ram_req_type                    ram_req,
   input  wire logic [lsf_pkg::ADDRESS_BITS-1:0]       ram_rdata
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [lsf_pkg::PORT_COUNT-1:0]      connected_ff, connected_in;
   logic [lsf_pkg::PORT_COUNT-1:0]      lvalid_ff, lvalid_in;
   logic [lsf_pkg::PORT_BITS-1:0]       idx_ff, idx_in;
   logic                                cmp_vld_ff, cmp_vld_in;
   logic [lsf_pkg::PORT_BITS-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                                hit_ff, hit_in;
   logic [lsf_pkg::PORT_BITS-1:0]       win_ff, win_in;
   logic [lsf_pkg::PORT_BITS-1:0]       port_ff, port_in;
   logic [lsf_pkg::ADDRESS_BITS-1:0]    dst_ff, dst_in;
   logic                                strobe_ff, strobe_in;
   lsf_pkg::lsf_rsp_type                rsp_ff, rsp_in;

   logic [lsf_pkg::PORT_COUNT-1:0]      free_ports;
   logic [lsf_pkg::PORT_BITS-1:0]       free_sel;
   logic                                port_ok;
   logic                                match_now;
   logic                                final_hit;
   logic [lsf_pkg::PORT_BITS-1:0]       final_win;

   always_comb begin
      free_ports = ~connected_ff & enable_mask;
      free_sel   = '0;
      for (int i = lsf_pkg::PORT_COUNT - 1; i >= 0; i--) begin
         if (free_ports[i]) begin
            free_sel = lsf_pkg::PORT_BITS'(i);
         end
      end
   end

   assign port_ok   = lsf_pkg::CSR_BITS'(req.port) < port_count;
   assign match_now = cmp_vld_ff && connected_ff[cmp_idx_ff] && lvalid_ff[cmp_idx_ff]
                      && (ram_rdata == dst_ff);
   assign final_hit = hit_ff || match_now;
   assign final_win = match_now ? cmp_idx_ff : win_ff;

   always_comb begin
      state_in     = state_ff;
      connected_in = connected_ff;
      lvalid_in    = lvalid_ff;
      idx_in       = idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = idx_ff;
      hit_in       = hit_ff;
      win_in       = win_ff;
      port_in      = port_ff;
      dst_in       = dst_ff;
      strobe_in    = 1'b0;
      rsp_in       = '0;
      ram_req.we    = 1'b0;
      ram_req.addr  = idx_ff;
      ram_req.wdata = req.source_address;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req.operation)
                  lsf_pkg::OP_CONNECT: begin
                     strobe_in = 1'b1;
                     if (|free_ports) begin
                        connected_in[free_sel] = 1'b1;
                        lvalid_in[free_sel]    = 1'b0;
                        rsp_in.accepted        = 1'b1;
                        rsp_in.assigned_port   = free_sel;
                     end
                  end
                  lsf_pkg::OP_DISCONNECT: begin
                     strobe_in = 1'b1;
                     if (port_ok) begin
                        connected_in[req.port] = 1'b0;
                        lvalid_in[req.port]    = 1'b0;
                     end
                  end
                  lsf_pkg::OP_FRAME: begin
                     if (port_ok && connected_ff[req.port]) begin
                        if (!lvalid_ff[req.port]) begin
                           ram_req.we          = 1'b1;
                           ram_req.addr        = req.port;
                           lvalid_in[req.port] = 1'b1;
                        end
                        port_in  = req.port;
                        dst_in   = req.destination_address;
                        idx_in   = '0;
                        hit_in   = 1'b0;
                        win_in   = '0;
                        state_in = ST_SCAN;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmp_vld_in = 1'b1;
            cmp_idx_in = idx_ff;
            if (match_now) begin
               hit_in = 1'b1;
               win_in = cmp_idx_ff;
            end
            if (lsf_pkg::CSR_BITS'(idx_ff) == port_count - lsf_pkg::CSR_BITS'(1)) begin
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + lsf_pkg::PORT_BITS'(1);
            end
         end
         ST_DRAIN: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
            if (final_hit) begin
               rsp_in.destination_found = 1'b1;
               rsp_in.forward_mask      = lsf_pkg::PORT_COUNT'(1) << final_win;
            end else begin
               rsp_in.forward_mask = connected_ff & enable_mask
                                     & ~(lsf_pkg::PORT_COUNT'(1) << port_ff);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         connected_ff <= '0;
         lvalid_ff    <= '0;
         cmp_vld_ff   <= 1'b0;
         strobe_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         connected_ff <= connected_in;
         lvalid_ff    <= lvalid_in;
         cmp_vld_ff   <= cmp_vld_in;
         strobe_ff    <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      hit_ff     <= hit_in;
      win_ff     <= win_in;
      port_ff    <= port_in;
      dst_ff     <= dst_in;
      rsp_ff     <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp        = rsp_ff;

endmodule

`default_nettype wire

FILE: rtl/learning_switch_forwarder_core.sv
// ----------------------------------------------------------------------------
// learning_switch_forwarder_core
// Learning switch port table: connect, disconnect and frame forwarding.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request gives
// exactly one response, shown on rsp for one cycle with rsp_strobe high; the
// receiver must take it then.
// Connect, disconnect, unused codes and frames on an unconnected or disabled
// port: response in the cycle after the request, busy stays low, so one
// request per cycle is possible.
// Frame on a connected enabled port: the learned address table sits in a
// single-port RAM that is read one port per cycle, so a frame steps through
// ST_SCAN once per enabled port (ports_in_use, capped at eight) and then
// ST_DRAIN; busy is high meanwhile and falls in the cycle the response is
// shown.
// csr_write_enable/csr_write_data set ports_in_use; write only while idle.
// Reset clears all port and learned flags, sets ports_in_use to 8 and
// needs no clearing pass; stale table entries are masked by valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module learning_switch_forwarder_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire lsf_pkg::lsf_req_type          req,
   output logic                               rsp_strobe,
   output lsf_pkg::lsf_rsp_type               rsp,
   input  wire logic                          csr_write_enable,
   input  wire logic [lsf_pkg::CSR_BITS-1:0]  csr_write_data
);

   logic [lsf_pkg::CSR_BITS-1:0]     ports_in_use_ff, ports_in_use_in;
   logic [lsf_pkg::CSR_BITS-1:0]     port_count;
   logic [lsf_pkg::PORT_COUNT-1:0]   enable_mask;
   lsf_pkg::lsf_ram_req_type         ram_req;
   logic [lsf_pkg::ADDRESS_BITS-1:0] ram_rdata;

   assign ports_in_use_in = csr_write_enable ? csr_write_data : ports_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ports_in_use_ff <= lsf_pkg::CSR_RESET;
      end else begin
         ports_in_use_ff <= ports_in_use_in;
      end
   end

   // clamp to the physical port count
   assign port_count = (ports_in_use_ff > lsf_pkg::CSR_BITS'(lsf_pkg::PORT_COUNT))
                       ? lsf_pkg::CSR_BITS'(lsf_pkg::PORT_COUNT) : ports_in_use_ff;

   always_comb begin
      for (int i = 0; i < lsf_pkg::PORT_COUNT; i++) begin
         enable_mask[i] = lsf_pkg::CSR_BITS'(i) < port_count;
      end
   end

   lsf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req         (req),
      .rsp_strobe  (rsp_strobe),
      .rsp         (rsp),
      .port_count  (port_count),
      .enable_mask (enable_mask),
      .ram_req     (ram_req),
      .ram_rdata   (ram_rdata)
   );

   lsf_ram #(
      .WIDTH (lsf_pkg::ADDRESS_BITS),
      .DEPTH (lsf_pkg::PORT_COUNT)
   ) u_addr_ram (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

FILE: rtl/lsf_checker.sv
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks for learning_switch_forwarder_core, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module lsf_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          start,
   input wire logic                          busy,
   input wire lsf_pkg::lsf_req_type          req,
   input wire logic                          rsp_strobe,
   input wire lsf_pkg::lsf_rsp_type          rsp
);

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(start && !busy) || $fell(busy)))
      else $error("response without a request behind it");

   a_frame_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req.operation == lsf_pkg::OP_FRAME) |=> (busy || rsp_strobe))
      else $error("frame request neither in progress nor answered");

   a_unicast_onehot: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.destination_found) |-> $onehot(rsp.forward_mask))
      else $error("unicast response without a single port");

   a_connect_no_fwd: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp.accepted) |-> (rsp.forward_mask == '0 && !rsp.destination_found))
      else $error("connect response carries forwarding data");

   a_reject_no_port: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp.accepted) |-> (rsp.assigned_port == '0))
      else $error("port number on a response that assigns none");

endmodule

bind learning_switch_forwarder_core lsf_checker u_lsf_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req        (req),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);

`default_nettype wire
